FILE: sv/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared constants and helpers for the moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int CFG_W           = 5;
  localparam int CFG_RESET       = 3;
  localparam int AVG_W           = 24;
  localparam int FRAC_BITS       = 8;
  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Clamp the programmed length into 1 .. max_window.
  function automatic int unsigned eff_len(input logic [CFG_W-1:0] cfg,
                                          input int unsigned max_window);
    int unsigned v;
    v = int'(cfg);
    if (v == 0) begin
      v = 1;
    end else if (v > max_window) begin
      v = max_window;
    end
    return v;
  endfunction

endpackage

FILE: sv/moving_average_filter_core.sv
// ----------------------------------------------------------------------------
// moving_average_filter_core
// Simple moving average over the last 1..MAX_WINDOW samples, 8 fraction bits.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / data            tuser
//  s_axis    in         sample                  start_req
//  m_axis    out        average (24 bits)       window_full
//  cfg       in         window_length (5 bits)  -
//
//  A sample in a full window passes ST_READ, the bit-serial divider in ST_DIV
//  and ST_DONE; warm-up samples go from ST_READ straight to ST_DONE.
//  The ring is read and written in the accept cycle.
//  Reset sets window_length to 3 and clears warm-up; the ring needs no clear.
//  A stalled result waits in the output register; the next sample may enter.
// ----------------------------------------------------------------------------
module moving_average_filter_core
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: [SAMPLE_BITS-1:0] sample, rest zero
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // tuser: [0] start_req
  input  logic                                 s_axis_tuser_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: [23:0] average
  output logic [AVG_W-1:0]                     m_axis_tdata_o,
  // tuser: [0] window_full
  output logic                                 m_axis_tuser_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic [CFG_W-1:0]                     cfg_data_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int DVD_W = SUM_W + FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CFG_W-1:0]       len_cfg_q;
  logic [LEN_W-1:0]       fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [PTR_W-1:0]       wp_q, wp_d;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic                   start_q;
  logic [AVG_W-1:0]       res_avg_q, res_avg_d;
  logic                   res_full_q, res_full_d;
  logic [AVG_W-1:0]       out_avg_q;
  logic                   out_full_q;
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;

  logic                   in_acc;
  logic                   cfg_acc;
  logic [LEN_W-1:0]       len;
  logic [PTR_W:0]         oldest_ext;
  logic [PTR_W-1:0]       oldest;
  logic [SAMPLE_BITS-1:0] ring_rd;

  logic [LEN_W-1:0]       fill_base;
  logic [SUM_W-1:0]       sum_base;
  logic                   full_before;
  logic [SUM_W-1:0]       sum_new;
  logic [LEN_W-1:0]       fill_new;
  logic                   full_after;

  logic                   div_start;
  logic                   div_done;
  logic [DVD_W-1:0]       quotient;

  assign len     = LEN_W'(eff_len(len_cfg_q, MAX_WINDOW));
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;

  // oldest slot of the window, relative to the slot being written
  assign oldest_ext = {1'b0, wp_q} + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(len);
  assign oldest     = (oldest_ext >= (PTR_W+1)'(MAX_WINDOW))
                    ? PTR_W'(oldest_ext - (PTR_W+1)'(MAX_WINDOW))
                    : oldest_ext[PTR_W-1:0];

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .raddr_i (oldest),
    .rdata_o (ring_rd)
  );

  // update the running sum once the evicted sample is back
  assign fill_base   = start_q ? '0 : fill_q;
  assign sum_base    = start_q ? '0 : sum_q;
  assign full_before = (fill_base >= len);
  assign sum_new     = sum_base - (full_before ? SUM_W'(ring_rd) : '0) + SUM_W'(smp_q);
  assign fill_new    = full_before ? fill_base : fill_base + LEN_W'(1);
  assign full_after  = (fill_new >= len);
  assign div_start   = (state_q == ST_READ) && full_after;

  mavg_div #(
    .DVD_W (DVD_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_new, FRAC_BITS'(0)}),
    .divisor_i  (len),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    wp_d        = wp_q;
    res_avg_d   = res_avg_q;
    res_full_d  = res_full_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wp_d    = (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        fill_d     = fill_new;
        sum_d      = sum_new;
        res_avg_d  = '0;
        res_full_d = full_after;
        state_d    = full_after ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          res_avg_d = AVG_W'(quotient);
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a new length restarts warm-up
    if (cfg_acc) begin
      fill_d = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_cfg_q   <= CFG_W'(CFG_RESET);
      fill_q      <= '0;
      sum_q       <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      if (cfg_acc) begin
        len_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_avg_q  <= res_avg_d;
    res_full_q <= res_full_d;
    if (in_acc) begin
      smp_q   <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      start_q <= s_axis_tuser_i;
    end
    if (out_load) begin
      out_avg_q  <= res_avg_q;
      out_full_q <= res_full_q;
    end
  end

  assign m_axis_tdata_o  = out_avg_q;
  assign m_axis_tuser_o  = out_full_q;
  assign m_axis_tvalid_o = out_valid_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len)
    else $error("fill count above window length");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside division state");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_DONE)
    else $error("result appeared without a finished request");

  a_warmup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tdata_o == '0)
    else $error("nonzero average during warm-up");

endmodule

FILE: sv/mavg_ram.sv
// ----------------------------------------------------------------------------
// mavg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Restoring bit-serial divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mavg_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic             qbit;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], qbit};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("remainder not below divisor");

  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done while still busy");

endmodule
